// ===== rtl/kcc_pkg.sv =====
// shared types, constants and reset values of the key click classifier
package kcc_pkg;

	localparam int KEY_COUNT_DEF = 4;
	localparam int TIME_BITS_DEF = 32;
	localparam int LEVEL_BITS    = 4;
	localparam int PADDR_BITS    = 4;
	localparam int PDATA_BITS    = 32;
	localparam int CFG_BITS      = 16;
	localparam int CLICK_BITS    = 8;

	localparam logic [CLICK_BITS-1:0] CLICK_MAX = 8'd255;

	localparam logic [CFG_BITS-1:0] CONFIRM_RST = 16'd20;
	localparam logic [CFG_BITS-1:0] WINDOW_RST  = 16'd300;
	localparam logic [CFG_BITS-1:0] LONG_RST    = 16'd1000;

	localparam logic [1:0] REG_CONFIRM = 2'd0;
	localparam logic [1:0] REG_WINDOW  = 2'd1;
	localparam logic [1:0] REG_LONG    = 2'd2;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_CONFIRM  = 2'd1,
		PH_SHORT    = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_DOUBLE = 2'd2,
		KIND_LONG   = 2'd3
	} kind_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_SCAN = 1'b1
	} seq_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] confirm_ms;
		logic [CFG_BITS-1:0] double_click_window;
		logic [CFG_BITS-1:0] long_press_time;
	} cfg_t;

endpackage

// ===== rtl/kcc_if.sv =====
// poll and result stream interfaces
interface kcc_in_if #(parameter int TIME_BITS = kcc_pkg::TIME_BITS_DEF);
	logic                              valid;
	logic                              ready;
	logic [TIME_BITS-1:0]              now_ms;
	logic [kcc_pkg::LEVEL_BITS-1:0]    key_levels;

	modport source(output valid, now_ms, key_levels, input ready);
	modport sink(input valid, now_ms, key_levels, output ready);
endinterface

interface kcc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] press_kind;
	logic [1:0] key_number;

	modport source(output valid, press_kind, key_number, input ready);
	modport sink(input valid, press_kind, key_number, output ready);
endinterface

// ===== rtl/kcc_cfg_regs.sv =====
// apb configuration registers
module kcc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kcc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [kcc_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [kcc_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready,
	output kcc_pkg::cfg_t                     cfg
);

	kcc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_ms          <= kcc_pkg::CONFIRM_RST;
			cfg_q.double_click_window <= kcc_pkg::WINDOW_RST;
			cfg_q.long_press_time     <= kcc_pkg::LONG_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				kcc_pkg::REG_CONFIRM: cfg_q.confirm_ms <= pwdata[15:0];
				kcc_pkg::REG_WINDOW:  cfg_q.double_click_window <= pwdata[15:0];
				kcc_pkg::REG_LONG:    cfg_q.long_press_time <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			kcc_pkg::REG_CONFIRM: prdata = {16'd0, cfg_q.confirm_ms};
			kcc_pkg::REG_WINDOW:  prdata = {16'd0, cfg_q.double_click_window};
			kcc_pkg::REG_LONG:    prdata = {16'd0, cfg_q.long_press_time};
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== rtl/kcc_state_mem.sv =====
// per-key state memory with registered read and entry valid bits
module kcc_state_mem #(
	parameter int KEY_COUNT = kcc_pkg::KEY_COUNT_DEF,
	parameter int TIME_BITS = kcc_pkg::TIME_BITS_DEF,
	parameter int KW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [KW-1:0]                       rd_addr,
	output kcc_pkg::phase_t                     rd_phase,
	output logic [kcc_pkg::CLICK_BITS-1:0]      rd_click,
	output logic [TIME_BITS-1:0]                rd_press,
	output logic [TIME_BITS-1:0]                rd_rel,
	input  logic                                wr_en,
	input  logic [KW-1:0]                       wr_addr,
	input  kcc_pkg::phase_t                     wr_phase,
	input  logic [kcc_pkg::CLICK_BITS-1:0]      wr_click,
	input  logic [TIME_BITS-1:0]                wr_press,
	input  logic [TIME_BITS-1:0]                wr_rel
);

	localparam int W = 2 + kcc_pkg::CLICK_BITS + 2 * TIME_BITS;

	logic [W-1:0]         mem_q [KEY_COUNT];
	logic [W-1:0]         rd_data_q;
	logic [KEY_COUNT-1:0] vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_phase, wr_click, wr_press, wr_rel};
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as released with no pending clicks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_phase = rd_vld_q ? kcc_pkg::phase_t'(rd_data_q[W-1 -: 2])
	                           : kcc_pkg::PH_RELEASED;
	assign rd_click = rd_vld_q ? rd_data_q[W-3 -: kcc_pkg::CLICK_BITS] : '0;
	assign rd_press = rd_data_q[2*TIME_BITS-1 -: TIME_BITS];
	assign rd_rel   = rd_data_q[TIME_BITS-1:0];

endmodule

// ===== rtl/kcc_key_eval.sv =====
// next-state and report logic for one key
module kcc_key_eval #(
	parameter int TIME_BITS = kcc_pkg::TIME_BITS_DEF
) (
	input  kcc_pkg::cfg_t                       cfg,
	input  logic [TIME_BITS-1:0]                now,
	input  logic                                pressed,
	input  kcc_pkg::phase_t                     phase,
	input  logic [kcc_pkg::CLICK_BITS-1:0]      click,
	input  logic [TIME_BITS-1:0]                press_start,
	input  logic [TIME_BITS-1:0]                first_rel,
	output kcc_pkg::phase_t                     nx_phase,
	output logic [kcc_pkg::CLICK_BITS-1:0]      nx_click,
	output logic [TIME_BITS-1:0]                nx_press,
	output logic [TIME_BITS-1:0]                nx_rel,
	output kcc_pkg::kind_t                      kind
);

	logic [TIME_BITS-1:0]               el_press;
	logic [TIME_BITS-1:0]               el_rel;
	logic [TIME_BITS-1:0]               confirm_ext;
	logic [TIME_BITS-1:0]               window_ext;
	logic [TIME_BITS-1:0]               long_ext;
	logic [kcc_pkg::CLICK_BITS-1:0]     click_inc;

	// wrapping differences
	assign el_press    = now - press_start;
	assign el_rel      = now - first_rel;
	assign confirm_ext = TIME_BITS'(cfg.confirm_ms);
	assign window_ext  = TIME_BITS'(cfg.double_click_window);
	assign long_ext    = TIME_BITS'(cfg.long_press_time);
	assign click_inc   = (click == kcc_pkg::CLICK_MAX) ? click : click + 1'b1;

	always_comb begin
		nx_phase = phase;
		nx_click = click;
		nx_press = press_start;
		nx_rel   = first_rel;
		kind     = kcc_pkg::KIND_NONE;
		case (phase)
			kcc_pkg::PH_RELEASED: begin
				if (pressed) begin
					nx_phase = kcc_pkg::PH_CONFIRM;
					nx_press = now;
				end else if (click != '0 && el_rel > window_ext) begin
					nx_click = '0;
					kind     = kcc_pkg::KIND_SINGLE;
				end
			end
			kcc_pkg::PH_CONFIRM: begin
				if (!pressed) begin
					nx_phase = kcc_pkg::PH_RELEASED;
				end else if (el_press > confirm_ext) begin
					nx_phase = kcc_pkg::PH_SHORT;
				end
			end
			kcc_pkg::PH_SHORT: begin
				if (!pressed) begin
					nx_phase = kcc_pkg::PH_RELEASED;
					nx_click = click_inc;
					if (click_inc == 8'd1) begin
						nx_rel = now;
					end else if (el_rel <= window_ext) begin
						nx_click = '0;
						kind     = kcc_pkg::KIND_DOUBLE;
					end
				end else if (el_press > long_ext) begin
					nx_phase = kcc_pkg::PH_LONG;
				end
			end
			default: begin
				if (!pressed) begin
					nx_phase = kcc_pkg::PH_RELEASED;
					kind     = kcc_pkg::KIND_LONG;
				end
			end
		endcase
	end

endmodule

// ===== rtl/key_click_classifier.sv =====
// top level of the key click classifier
//
// in_ch carries one poll per transfer: the wrapping millisecond time now_ms and
// the raw active-low levels of the keys (keys past the level bits read pressed).
// out_ch returns exactly one result per poll: press_kind (none, single, double,
// long) and key_number of the reporting key, zero when nothing is reported.
// the apb port holds the confirm time, double_click_window and long_press_time
// at byte addresses 0, 4 and 8; write them only while no poll is in flight.
// per-key state sits in one memory with a registered read. the
// sequencer reads key k+1 while it evaluates and writes back key k, and the
// scan stops at the first reporting key. a new poll is taken only once the
// scan of the last one has finished, as the state memory has a single read
// port that is visited once per key.
// reset clears the configuration to its defaults and marks all keys released
// with no pending clicks through per-entry valid bits, no clearing pass.
// a stalled result holds in the output register; the next poll is taken only
// when that register is empty or is being drained in the same cycle.
module key_click_classifier #(
	parameter int KEY_COUNT = kcc_pkg::KEY_COUNT_DEF,
	parameter int TIME_BITS = kcc_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	kcc_in_if.sink                            in_ch,
	kcc_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kcc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [kcc_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [kcc_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready
);

	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [KW-1:0] LAST_KEY = KW'(KEY_COUNT - 1);

	kcc_pkg::cfg_t   cfg;
	kcc_pkg::seq_t   state_q, state_nx;

	// poll registers
	logic [TIME_BITS-1:0]             now_q;
	logic [kcc_pkg::LEVEL_BITS-1:0]   levels_q;
	logic [KW-1:0]                    key_q;
	logic [KEY_COUNT-1:0]             lv_full;

	// memory side
	logic                             rd_en;
	logic [KW-1:0]                    rd_addr;
	logic                             wr_en;
	kcc_pkg::phase_t                  rd_phase, nx_phase;
	logic [kcc_pkg::CLICK_BITS-1:0]   rd_click, nx_click;
	logic [TIME_BITS-1:0]             rd_press, nx_press;
	logic [TIME_BITS-1:0]             rd_rel, nx_rel;
	kcc_pkg::kind_t                   kind;

	// control
	logic                             in_fire;
	logic                             is_last;
	logic                             finish;
	logic                             out_valid_q;
	logic [1:0]                       kind_q;
	logic [1:0]                       num_q;

	kcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kcc_state_mem #(
		.KEY_COUNT (KEY_COUNT),
		.TIME_BITS (TIME_BITS),
		.KW        (KW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_phase (rd_phase),
		.rd_click (rd_click),
		.rd_press (rd_press),
		.rd_rel   (rd_rel),
		.wr_en    (wr_en),
		.wr_addr  (key_q),
		.wr_phase (nx_phase),
		.wr_click (nx_click),
		.wr_press (nx_press),
		.wr_rel   (nx_rel)
	);

	// keys beyond the level bits read as pressed
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lv
		if (k < kcc_pkg::LEVEL_BITS) begin : g_bit
			assign lv_full[k] = levels_q[k];
		end else begin : g_none
			assign lv_full[k] = 1'b0;
		end
	end

	kcc_key_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.cfg         (cfg),
		.now         (now_q),
		.pressed     (~lv_full[key_q]),
		.phase       (rd_phase),
		.click       (rd_click),
		.press_start (rd_press),
		.first_rel   (rd_rel),
		.nx_phase    (nx_phase),
		.nx_click    (nx_click),
		.nx_press    (nx_press),
		.nx_rel      (nx_rel),
		.kind        (kind)
	);

	assign in_fire = in_ch.valid & in_ch.ready;
	assign is_last = (key_q == LAST_KEY);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			kcc_pkg::SEQ_IDLE: if (in_fire) state_nx = kcc_pkg::SEQ_SCAN;
			kcc_pkg::SEQ_SCAN: if (finish) state_nx = kcc_pkg::SEQ_IDLE;
			default:           state_nx = kcc_pkg::SEQ_IDLE;
		endcase
	end

	// sequencer outputs: read of key 0 on the poll transfer, then read-ahead
	always_comb begin
		in_ch.ready = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			kcc_pkg::SEQ_IDLE: begin
				in_ch.ready = ~out_valid_q | out_ch.ready;
				rd_en       = in_fire;
			end
			kcc_pkg::SEQ_SCAN: begin
				wr_en   = 1'b1;
				finish  = is_last | (kind != kcc_pkg::KIND_NONE);
				rd_en   = ~finish;
				rd_addr = key_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcc_pkg::SEQ_IDLE;
			key_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_fire) begin
				key_q <= '0;
			end else if (state_q == kcc_pkg::SEQ_SCAN && !finish) begin
				key_q <= key_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q    <= in_ch.now_ms;
			levels_q <= in_ch.key_levels;
		end
		if (finish) begin
			kind_q <= kind;
			num_q  <= (kind == kcc_pkg::KIND_NONE) ? 2'd0 : 2'(key_q);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.press_kind = kind_q;
	assign out_ch.key_number = num_q;

endmodule
